@@ design/rtt_pkg.sv @@
// Shared constants for the region tag table: field widths, action and status codes.
// No dependencies; every other file of the block imports this package.
package rtt_pkg;

  localparam int DEF_ENTRIES   = 64;
  localparam int DEF_ADDR_BITS = 48;

  localparam int ACT_W   = 2;
  localparam int SIZE_W  = 32;
  localparam int TAG_W   = 8;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 7;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CHECK  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_DUP  = 2'd2;
  localparam logic [ST_W-1:0] ST_MISS = 2'd3;

endpackage

@@ design/rtt_req_if.sv @@
// Request channel of the region tag table: valid/ready plus one request word.
// Depends on rtt_pkg for field widths.
interface rtt_req_if #(
  parameter int ADDR_BITS = rtt_pkg::DEF_ADDR_BITS
);
  import rtt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [ADDR_BITS-1:0] address;
  logic [SIZE_W-1:0]    region_size;
  logic [TAG_W-1:0]     region_tag;
  logic [TAG_W-1:0]     expected_tag;

  modport source (
    output valid, action, address, region_size, region_tag, expected_tag,
    input  ready
  );
  modport sink (
    input  valid, action, address, region_size, region_tag, expected_tag,
    output ready
  );
endinterface

@@ design/rtt_rsp_if.sv @@
// Response channel of the region tag table: valid/ready plus one result word.
// Depends on rtt_pkg for field widths.
interface rtt_rsp_if;
  import rtt_pkg::*;

  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic               tag_match;
  logic [COUNT_W-1:0] entry_count;

  modport source (
    output valid, status, tag_match, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, tag_match, entry_count,
    output ready
  );
endinterface

@@ design/rtt_cell.sv @@
// Storage cell of one table slot: valid bit, base, size and tag, with the
// base and coverage compares against the word passing by. Depends on rtt_pkg.
module rtt_cell #(
  parameter int ADDR_BITS = rtt_pkg::DEF_ADDR_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       set,
  input  logic                       clear,
  input  logic [ADDR_BITS-1:0]       set_base,
  input  logic [rtt_pkg::SIZE_W-1:0] set_size,
  input  logic [rtt_pkg::TAG_W-1:0]  set_tag,
  input  logic [ADDR_BITS-1:0]       probe,
  input  logic [rtt_pkg::TAG_W-1:0]  expect_tag,
  output logic                       valid,
  output logic                       base_hit,
  output logic                       covers,
  output logic                       tag_eq
);
  import rtt_pkg::*;

  localparam int CMP_W = (ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W;

  logic [ADDR_BITS-1:0] base;
  logic [SIZE_W-1:0]    size;
  logic [TAG_W-1:0]     tag;
  logic [ADDR_BITS:0]   diff;

  // addr in [base, base+size): no borrow, and offset below size
  assign base_hit = valid && (base == probe);
  assign diff     = {1'b0, probe} - {1'b0, base};
  assign covers   = valid && !diff[ADDR_BITS]
                    && (CMP_W'(diff[ADDR_BITS-1:0]) < CMP_W'(size));
  assign tag_eq   = (tag == expect_tag);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (set) begin
      valid <= 1'b1;
    end else if (clear) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (set) begin
      base <= set_base;
      size <= set_size;
      tag  <= set_tag;
    end
  end

endmodule

@@ design/rtt_slot.sv @@
// One link of the slot chain: a storage cell plus a register stage that
// passes the request word on to the next slot. Depends on rtt_pkg and rtt_cell.
module rtt_slot #(
  parameter int ENTRIES   = rtt_pkg::DEF_ENTRIES,
  parameter int ADDR_BITS = rtt_pkg::DEF_ADDR_BITS,
  parameter int IDX       = 0,
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int WORD_W   = 1 + rtt_pkg::ACT_W + ADDR_BITS + rtt_pkg::SIZE_W
                            + 2 * rtt_pkg::TAG_W + 2 + IDX_W + 2,
  localparam int WR_W     = 1 + IDX_W + ADDR_BITS + rtt_pkg::SIZE_W + rtt_pkg::TAG_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] word_in,
  output logic [WORD_W-1:0] word_out,
  input  logic [WR_W-1:0]   wr_in
);
  import rtt_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  typedef struct packed {
    logic                 vld;
    logic [ACT_W-1:0]     action;
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_W-1:0]    size;
    logic [TAG_W-1:0]     tag;
    logic [TAG_W-1:0]     expect_tag;
    logic                 dup;
    logic                 have_free;
    logic [IDX_W-1:0]     free_idx;
    logic                 hit;
    logic                 match;
  } word_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [ADDR_BITS-1:0] base;
    logic [SIZE_W-1:0]    size;
    logic [TAG_W-1:0]     tag;
  } wr_t;

  word_t w_in;
  word_t w_next;
  word_t w_reg;
  wr_t   wr;

  logic valid;
  logic base_hit;
  logic covers;
  logic tag_eq;
  logic set;
  logic clear;

  assign w_in     = word_t'(word_in);
  assign wr       = wr_t'(wr_in);
  assign word_out = WORD_W'(w_reg);

  assign set   = wr.en && (wr.idx == MY_IDX);
  assign clear = w_in.vld && (w_in.action == ACT_REMOVE) && base_hit;

  rtt_cell #(
    .ADDR_BITS (ADDR_BITS)
  ) u_cell (
    .clk        (clk),
    .rst        (rst),
    .set        (set),
    .clear      (clear),
    .set_base   (wr.base),
    .set_size   (wr.size),
    .set_tag    (wr.tag),
    .probe      (w_in.addr),
    .expect_tag (w_in.expect_tag),
    .valid      (valid),
    .base_hit   (base_hit),
    .covers     (covers),
    .tag_eq     (tag_eq)
  );

  always_comb begin
    w_next = w_in;
    if (w_in.vld) begin
      case (w_in.action)
        ACT_INSERT: begin
          if (base_hit) begin
            w_next.dup = 1'b1;
          end
          if (!valid && !w_in.have_free) begin
            w_next.have_free = 1'b1;
            w_next.free_idx  = MY_IDX;
          end
        end
        ACT_REMOVE: begin
          if (base_hit) begin
            w_next.hit = 1'b1;
          end
        end
        ACT_CHECK: begin
          if (covers) begin
            w_next.hit = 1'b1;
            if (tag_eq) begin
              w_next.match = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    w_reg.action     <= w_next.action;
    w_reg.addr       <= w_next.addr;
    w_reg.size       <= w_next.size;
    w_reg.tag        <= w_next.tag;
    w_reg.expect_tag <= w_next.expect_tag;
    w_reg.dup        <= w_next.dup;
    w_reg.have_free  <= w_next.have_free;
    w_reg.free_idx   <= w_next.free_idx;
    w_reg.hit        <= w_next.hit;
    w_reg.match      <= w_next.match;
    if (rst) begin
      w_reg.vld <= 1'b0;
    end else begin
      w_reg.vld <= w_in.vld;
    end
  end

endmodule

@@ design/region_tag_table.sv @@
// Region tag table top level: request intake, chain of slots, commit and result register.
// Depends on rtt_pkg, rtt_req_if, rtt_rsp_if and rtt_slot.
//
//   channel  dir  modport  word
//   -------  ---  -------  --------------------------------------------------
//   req      in   sink     action, address, region_size, region_tag, expected_tag
//   rsp      out  source   status, tag_match, entry_count
//
// One request at a time. A word walks the slot chain one slot per cycle, through
//   the register of each slot, to the result register; the intake reopens as the
//   result enters the result register, not while it waits in the park register.
// An insert commits at the chain tail, after every slot has been seen, so the
//   duplicate test and lowest-free-slot pick cover the whole table.
// Reset clears slot valid bits and the count at once; no clearing pass.
// A stalled rsp holds its word; the next request is taken meanwhile, and its
//   result parks in a second register until rsp drains.
module region_tag_table #(
  parameter int ENTRIES   = rtt_pkg::DEF_ENTRIES,
  parameter int ADDR_BITS = rtt_pkg::DEF_ADDR_BITS
) (
  input logic      clk,
  input logic      rst,
  rtt_req_if.sink   req,
  rtt_rsp_if.source rsp
);
  import rtt_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = 1 + ACT_W + ADDR_BITS + SIZE_W + 2 * TAG_W + 2 + IDX_W + 2;
  localparam int WR_W   = 1 + IDX_W + ADDR_BITS + SIZE_W + TAG_W;

  // request word as it travels the chain; flags accumulate slot by slot
  typedef struct packed {
    logic                 vld;
    logic [ACT_W-1:0]     action;
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_W-1:0]    size;
    logic [TAG_W-1:0]     tag;
    logic [TAG_W-1:0]     expect_tag;
    logic                 dup;        // insert: base already present
    logic                 have_free;  // insert: some slot is free
    logic [IDX_W-1:0]     free_idx;   // insert: lowest free slot
    logic                 hit;        // remove: base found; check: covered
    logic                 match;      // check: covering slot with equal tag
  } word_t;

  // insert commit, broadcast to every slot
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [ADDR_BITS-1:0] base;
    logic [SIZE_W-1:0]    size;
    logic [TAG_W-1:0]     tag;
  } wr_t;

  logic [WORD_W-1:0] chain [ENTRIES+1];
  word_t head;
  word_t tail;
  wr_t   wr;

  logic             flight;      // a request is inside the chain or parked
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic [ST_W-1:0]    res_status;
  logic               res_match;
  logic [COUNT_W-1:0] res_count;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  logic               out_valid;
  logic [ST_W-1:0]    out_status;
  logic               out_match;
  logic [COUNT_W-1:0] out_count;

  logic               park_valid;
  logic [ST_W-1:0]    park_status;
  logic               park_match;
  logic [COUNT_W-1:0] park_count;

  logic accept;
  logic out_free;

  assign req.ready = !flight;
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  always_comb begin
    head            = '0;
    head.vld        = accept;
    head.action     = req.action;
    head.addr       = req.address;
    head.size       = req.region_size;
    head.tag        = req.region_tag;
    head.expect_tag = req.expected_tag;
  end

  assign chain[0] = WORD_W'(head);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_slot
    rtt_slot #(
      .ENTRIES   (ENTRIES),
      .ADDR_BITS (ADDR_BITS),
      .IDX       (i)
    ) u_slot (
      .clk      (clk),
      .rst      (rst),
      .word_in  (chain[i]),
      .word_out (chain[i+1]),
      .wr_in    (WR_W'(wr))
    );
  end

  assign tail = word_t'(chain[ENTRIES]);

  // Resolve the request at the tail. Duplicate wins over full.
  always_comb begin
    res_status = ST_OK;
    res_match  = 1'b0;
    count_next = count;
    wr         = '0;
    wr.idx     = tail.free_idx;
    wr.base    = tail.addr;
    wr.size    = tail.size;
    wr.tag     = tail.tag;
    if (tail.vld) begin
      case (tail.action)
        ACT_INSERT: begin
          if (tail.dup) begin
            res_status = ST_DUP;
          end else if (!tail.have_free) begin
            res_status = ST_FULL;
          end else begin
            wr.en      = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        ACT_REMOVE: begin
          if (tail.hit) begin
            count_next = count - CNT_W'(1);
          end else begin
            res_status = ST_MISS;
          end
        end
        ACT_CHECK: begin
          if (tail.hit) begin
            res_match = tail.match;
          end else begin
            res_status = ST_MISS;
          end
        end
        default: ;
      endcase
    end
  end

  assign count_wide = (CNT_W + COUNT_W)'(count_next);
  assign res_count  = count_wide[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      flight     <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
      park_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        flight <= 1'b1;
      end
      if (tail.vld) begin
        if (out_free) begin
          out_valid <= 1'b1;
          flight    <= 1'b0;
        end else begin
          park_valid <= 1'b1;
        end
      end else if (park_valid && out_free) begin
        out_valid  <= 1'b1;
        park_valid <= 1'b0;
        flight     <= 1'b0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.vld) begin
      if (out_free) begin
        out_status <= res_status;
        out_match  <= res_match;
        out_count  <= res_count;
      end else begin
        park_status <= res_status;
        park_match  <= res_match;
        park_count  <= res_count;
      end
    end else if (park_valid && out_free) begin
      out_status <= park_status;
      out_match  <= park_match;
      out_count  <= park_count;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.tag_match   = out_match;
  assign rsp.entry_count = out_count;

  // a word reaches the tail only for a request still in flight
  a_tail_in_flight: assert property (@(posedge clk) disable iff (rst)
    tail.vld |-> flight)
    else $error("chain tail valid with no request in flight");

  // the park register is used only while its request holds the intake closed
  a_park_in_flight: assert property (@(posedge clk) disable iff (rst)
    park_valid |-> (flight && out_valid))
    else $error("parked result without a busy output register");

  // region count never exceeds the number of slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("region count above table size");

  // an insert commit always grows the count by one
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> count == $past(count) + CNT_W'(1))
    else $error("insert commit did not advance the count");

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for region_tag_table: random and directed insert/remove/check words.
// Depends on rtt_pkg, rtt_req_if, rtt_rsp_if and the region_tag_table RTL.
// A scoreboard class mirrors the region table and compares every result word in order.
module testbench;
  import rtt_pkg::*;

  localparam int ENTRIES      = DEF_ENTRIES;
  localparam int ADDR_BITS    = DEF_ADDR_BITS;
  localparam int ITEM_TARGET  = 1100;
  // Slowest pass: ~1200 words, each with the chain walk, the longest send gap and the
  // longest rsp stall; the limit is about four times that total.
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int LONG_HOLD    = 400;

  // Action code that leaves the table unchanged; the block still answers it with an OK result word.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [ADDR_BITS-1:0] ADDR_MAX = {ADDR_BITS{1'b1}};
  localparam logic [SIZE_W-1:0]    SIZE_MAX = {SIZE_W{1'b1}};

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [ADDR_BITS-1:0] address;
    logic [SIZE_W-1:0]    region_size;
    logic [TAG_W-1:0]     region_tag;
    logic [TAG_W-1:0]     expected_tag;
  } req_word_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic               tag_match;
    logic [COUNT_W-1:0] entry_count;
  } rsp_word_t;

  // Operation mix of a random phase.
  typedef enum {MIX_GROW, MIX_SHRINK, MIX_PROBE} mix_t;

  // Mirror of the region table plus the queue of result words still owed.
  class region_scoreboard;
    bit                 live    [ENTRIES];
    bit [ADDR_BITS-1:0] base_of [ENTRIES];
    bit [SIZE_W-1:0]    size_of [ENTRIES];
    bit [TAG_W-1:0]     tag_of  [ENTRIES];
    int unsigned        live_count;
    rsp_word_t          owed_q[$];
    int errors, n_results;
    int n_inserts, n_full, n_dup, n_removes, n_gone, n_checks, n_hits, n_misses;

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endtask

    // Table update and expected result for one accepted request word.
    function void note_request(req_word_t w);
      rsp_word_t r;
      bit        dup;
      bit        have_free;
      int        free_slot;
      r = '0;
      r.status = ST_OK;
      dup = 0;
      have_free = 0;
      free_slot = 0;
      case (w.action)
        ACT_INSERT: begin
          n_inserts++;
          for (int i = 0; i < ENTRIES; i++) begin
            if (live[i]) begin
              if (base_of[i] == w.address) dup = 1;
            end else if (!have_free) begin
              have_free = 1;
              free_slot = i;
            end
          end
          // duplicate wins over full
          if (dup) begin
            r.status = ST_DUP;
            n_dup++;
          end else if (!have_free) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            live[free_slot]    = 1;
            base_of[free_slot] = w.address;
            size_of[free_slot] = w.region_size;
            tag_of[free_slot]  = w.region_tag;
            live_count++;
          end
        end
        ACT_REMOVE: begin
          n_removes++;
          r.status = ST_MISS;
          for (int i = 0; i < ENTRIES; i++) begin
            if (live[i] && base_of[i] == w.address) begin
              live[i] = 0;
              if (live_count > 0) live_count--;
              r.status = ST_OK;
            end
          end
          if (r.status == ST_MISS) n_gone++;
        end
        ACT_CHECK: begin
          n_checks++;
          r.status = ST_MISS;
          for (int i = 0; i < ENTRIES; i++) begin
            // end never wraps: offset from base compared with size
            if (live[i] && w.address >= base_of[i] &&
                (w.address - base_of[i]) < size_of[i]) begin
              r.status = ST_OK;
              if (tag_of[i] == w.expected_tag) r.tag_match = 1'b1;
            end
          end
          if (r.tag_match) n_hits++;
          if (r.status == ST_MISS) n_misses++;
        end
        default: ;
      endcase
      r.entry_count = live_count[COUNT_W-1:0];
      owed_q.push_back(r);
    endfunction

    task check_result(rsp_word_t got);
      rsp_word_t want;
      n_results++;
      if (owed_q.size() == 0) begin
        report($sformatf("result word with nothing owed: status=%0d match=%0d count=%0d",
                         got.status, got.tag_match, got.entry_count));
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, want %0d", n_results, got.status,
                         want.status));
      if (got.tag_match !== want.tag_match)
        report($sformatf("result %0d tag_match %0d, want %0d", n_results, got.tag_match,
                         want.tag_match));
      if (got.entry_count !== want.entry_count)
        report($sformatf("result %0d entry_count %0d, want %0d", n_results,
                         got.entry_count, want.entry_count));
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rtt_req_if #(.ADDR_BITS(ADDR_BITS)) req_ch();
  rtt_rsp_if                          rsp_ch();

  region_tag_table #(
    .ENTRIES  (ENTRIES),
    .ADDR_BITS(ADDR_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  region_scoreboard sb = new();

  bit                 steady;       // both sides run without gaps while set
  int                 rsp_hold_req; // long receiver hold-off, in cycles
  int                 n_sent;       // request words sent, ignored ones excluded
  int unsigned        cycles;
  logic [ADDR_BITS-1:0] window_base; // clusters bases so regions overlap

  initial begin
    forever #10 clk = ~clk;
  end

  // All block inputs known from time zero.
  initial begin
    req_ch.valid        = 1'b0;
    req_ch.action       = ACT_INSERT;
    req_ch.address      = '0;
    req_ch.region_size  = '0;
    req_ch.region_tag   = '0;
    req_ch.expected_tag = '0;
    rsp_ch.ready        = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d result words still owed", cycles,
               sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Monitors: sampled at the rising edge, inputs change on the falling edge.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_request({req_ch.action, req_ch.address, req_ch.region_size,
                       req_ch.region_tag, req_ch.expected_tag});
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result({rsp_ch.status, rsp_ch.tag_match, rsp_ch.entry_count});
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stalls; a long hold-off when asked, counted here.
  initial begin
    int n;
    int held;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rsp_hold_req > 0) begin
        n = rsp_hold_req;
        rsp_hold_req = 0;
        held = 0;
        while (held < n) begin
          @(negedge clk);
          rsp_ch.ready <= 1'b0;
          held++;
        end
      end else begin
        n = gap_len();
        repeat (n) begin
          @(negedge clk);
          rsp_ch.ready <= 1'b0;
        end
        @(negedge clk);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic req_word_t mk(logic [ACT_W-1:0] act, logic [ADDR_BITS-1:0] addr,
                                   logic [SIZE_W-1:0] size, logic [TAG_W-1:0] rtag,
                                   logic [TAG_W-1:0] etag);
    req_word_t w;
    w.action       = act;
    w.address      = addr;
    w.region_size  = size;
    w.region_tag   = rtag;
    w.expected_tag = etag;
    return w;
  endfunction

  // Random slot that holds a region, or -1 for an empty table.
  function automatic int pick_live();
    int idx[$];
    for (int i = 0; i < ENTRIES; i++)
      if (sb.live[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(0, idx.size() - 1)];
  endfunction

  function automatic logic [ADDR_BITS-1:0] rand_addr();
    return ADDR_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return SIZE_MAX;
    if (r < 60) return $urandom_range(1, 'h2000);
    return $urandom;
  endfunction

  // Base for an insert: clustered, anywhere, or one already in the table.
  function automatic logic [ADDR_BITS-1:0] insert_base();
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = pick_live();
    if (r < 50) return window_base + $urandom_range(0, 'hFFFF);
    if (r < 85 || s < 0) return rand_addr();
    return sb.base_of[s];
  endfunction

  // Probe address: inside a live region, on its edges, or loose.
  function automatic req_word_t probe_word();
    req_word_t            w;
    int                   s;
    int                   r;
    logic [ADDR_BITS-1:0] b;
    logic [SIZE_W-1:0]    sz;
    w = mk(ACT_CHECK, '0, $urandom, TAG_W'($urandom), TAG_W'($urandom));
    s = pick_live();
    r = $urandom_range(0, 99);
    if (s < 0 || r < 20) begin
      w.address = r[0] ? rand_addr() : window_base + $urandom_range(0, 'h1FFFF);
      return w;
    end
    b  = sb.base_of[s];
    sz = sb.size_of[s];
    if (r < 70)      w.address = (sz == 0) ? b : b + ($urandom % sz);
    else if (r < 80) w.address = b + sz - 1;
    else if (r < 90) w.address = b + sz;
    else             w.address = b - 1;
    if ($urandom_range(0, 1)) w.expected_tag = sb.tag_of[s];
    return w;
  endfunction

  function automatic req_word_t make_word(mix_t mix);
    req_word_t w;
    int        r;
    int        ins_cut;
    int        rem_cut;
    int        s;
    case (mix)
      MIX_GROW:   begin ins_cut = 50; rem_cut = 65; end
      MIX_SHRINK: begin ins_cut = 15; rem_cut = 65; end
      default:    begin ins_cut = 10; rem_cut = 20; end
    endcase
    r = $urandom_range(0, 99);
    w = mk(ACT_UNUSED, rand_addr(), $urandom, TAG_W'($urandom), TAG_W'($urandom));
    if (r < ins_cut) begin
      w.action      = ACT_INSERT;
      w.address     = insert_base();
      w.region_size = rand_size();
    end else if (r < rem_cut) begin
      w.action = ACT_REMOVE;
      s = pick_live();
      if (s >= 0 && $urandom_range(0, 99) < 75) w.address = sb.base_of[s];
      else if ($urandom_range(0, 1))            w.address = insert_base();
    end else if (r < 97) begin
      w = probe_word();
    end
    return w;
  endfunction

  task automatic idle_req(int n);
    repeat (n) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
  endtask

  // Offer one request word and hold it until the block takes it.
  task automatic put_word(req_word_t w);
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.action       <= w.action;
    req_ch.address      <= w.address;
    req_ch.region_size  <= w.region_size;
    req_ch.region_tag   <= w.region_tag;
    req_ch.expected_tag <= w.expected_tag;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (w.action != ACT_UNUSED) n_sent++;
  endtask

  task automatic send(req_word_t w);
    idle_req(gap_len());
    put_word(w);
  endtask

  // Sender pause until every owed result word is back.
  task automatic drain();
    idle_req(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    req_word_t directed_q[$];
    mix_t      mix;
    int        phase;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    window_base = rand_addr();

    // Directed opening: empty table, field extremes, edges, overlap, ignored action.
    directed_q.push_back(mk(ACT_CHECK,  '0, '0, '0, '0));           // empty: miss
    directed_q.push_back(mk(ACT_REMOVE, '0, '0, '0, '0));           // empty: not found
    directed_q.push_back(mk(ACT_UNUSED, '0, '0, '0, '0));
    directed_q.push_back(mk(ACT_INSERT, '0, '0, '0, '0));           // zero size region
    directed_q.push_back(mk(ACT_CHECK,  '0, '0, '0, '0));           // never covered
    directed_q.push_back(mk(ACT_INSERT, ADDR_MAX, SIZE_MAX, 8'hFF, 8'h00));
    directed_q.push_back(mk(ACT_CHECK,  ADDR_MAX, '0, '0, 8'hFF));  // top byte, hit
    directed_q.push_back(mk(ACT_CHECK,  ADDR_MAX, '0, '0, 8'h00));  // covered, wrong tag
    directed_q.push_back(mk(ACT_INSERT, ADDR_MAX, 32'h10, 8'h11, 8'h00)); // duplicate
    directed_q.push_back(mk(ACT_INSERT, 48'h1000, 32'h100, 8'h5A, 8'h00));
    directed_q.push_back(mk(ACT_INSERT, 48'h1080, 32'h100, 8'hA5, 8'h00)); // overlaps
    directed_q.push_back(mk(ACT_CHECK,  48'h10C0, '0, '0, 8'hA5));
    directed_q.push_back(mk(ACT_CHECK,  48'h10C0, '0, '0, 8'h5A));
    directed_q.push_back(mk(ACT_CHECK,  48'h10C0, '0, '0, 8'h00));
    directed_q.push_back(mk(ACT_CHECK,  48'h0FFF, '0, '0, 8'h5A));  // just below base
    directed_q.push_back(mk(ACT_CHECK,  48'h10FF, '0, '0, 8'h5A));  // last byte
    directed_q.push_back(mk(ACT_CHECK,  48'h1180, '0, '0, 8'hA5));  // one past end
    directed_q.push_back(mk(ACT_CHECK,  48'h117F, '0, '0, 8'hA5));
    directed_q.push_back(mk(ACT_REMOVE, 48'h1234, '0, '0, '0));     // absent base
    directed_q.push_back(mk(ACT_REMOVE, 48'h1080, '0, '0, '0));
    directed_q.push_back(mk(ACT_CHECK,  48'h10C0, '0, '0, 8'hA5));  // only first region left
    directed_q.push_back(mk(ACT_UNUSED, ADDR_MAX, SIZE_MAX, 8'hFF, 8'hFF));
    directed_q.push_back(mk(ACT_INSERT, 48'h1080, 32'h1, 8'h3C, 8'h00)); // reuses freed slot
    directed_q.push_back(mk(ACT_INSERT, 48'hFFFF_0000_0000, SIZE_MAX, 8'h81, 8'h00));
    directed_q.push_back(mk(ACT_CHECK,  48'hFFFF_FFFF_FFFE, '0, '0, 8'h81));
    foreach (directed_q[i]) send(directed_q[i]);
    drain();

    // Fill the table back to back, then hit it when full, with fresh bases and then a duplicate base.
    steady = 1;
    while (sb.live_count < ENTRIES) begin
      put_word(mk(ACT_INSERT, insert_base(), rand_size(), TAG_W'($urandom),
                  TAG_W'($urandom)));
      if (sb.pending() > 2) drain();
    end
    steady = 0;
    drain();
    repeat (3) send(mk(ACT_INSERT, rand_addr(), rand_size(), TAG_W'($urandom),
                       TAG_W'($urandom)));
    send(mk(ACT_INSERT, sb.base_of[$urandom_range(0, ENTRIES - 1)], '0, TAG_W'($urandom),
            '0));
    repeat (6) send(probe_word());

    // Random phases: grow, shrink and probe in turn, fresh clusters each time.
    phase = 0;
    while (n_sent < ITEM_TARGET) begin
      mix = mix_t'(phase % 3);
      steady = (phase % 4 == 2);
      window_base = rand_addr();
      if (phase == 3) begin
        // Receiver holds off while words keep coming; the input must stall.
        rsp_hold_req = LONG_HOLD;
        repeat (30) put_word(make_word(mix));
      end
      repeat (100) send(make_word(mix));
      if (phase % 3 == 1) drain();
      phase++;
    end
    steady = 0;

    drain();
    repeat (ENTRIES + 16) @(posedge clk);

    $display("ran %0d words: %0d inserts (%0d full, %0d duplicate), %0d removes (%0d absent)",
             n_sent, sb.n_inserts, sb.n_full, sb.n_dup, sb.n_removes, sb.n_gone);
    $display("%0d checks with %0d tag hits and %0d misses; %0d results, %0d mismatches",
             sb.n_checks, sb.n_hits, sb.n_misses, sb.n_results, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
